FILE: design/rst_pkg.sv
// ----------------------------------------------------------------------------
// rst_pkg
// Shared types, register indexes and helpers of the rest/sleep tracker.
// ----------------------------------------------------------------------------
package rst_pkg;

	localparam int COUNT_BITS = 16;
	localparam int TOL_W      = 26;
	localparam int LIM_W      = 14;
	localparam int MEAS_W     = 31;
	localparam int DIFF_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;
	localparam int CMP_W      = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;

	typedef logic [COUNT_BITS-1:0] cnt_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIN_TOL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_TOL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INT_TOL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_LIM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_LIM  = 3'd4;

	// reset values
	localparam logic [TOL_W-1:0] LIN_TOL_RST   = 26'd328;
	localparam logic [TOL_W-1:0] ANG_TOL_RST   = 26'd655;
	localparam logic [TOL_W-1:0] INT_TOL_RST   = 26'd13107;
	localparam logic [LIM_W-1:0] STILL_LIM_RST = 14'd15;
	localparam logic [LIM_W-1:0] SLEEP_LIM_RST = 14'd20;

	// commands
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WAKE  = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;
	localparam logic [1:0] CMD_BLOCK = 2'd3;

	// body modes
	localparam logic [1:0] MODE_AWAKE  = 2'd0;
	localparam logic [1:0] MODE_ASLEEP = 2'd1;
	localparam logic [1:0] MODE_DONE   = 2'd2;

	typedef struct packed {
		logic [TOL_W-1:0] lin_tol;
		logic [TOL_W-1:0] ang_tol;
		logic [TOL_W-1:0] int_tol;
		logic [LIM_W-1:0] still_lim;
		logic [LIM_W-1:0] sleep_lim;
	} cfg_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == {COUNT_BITS{1'b1}}) ? v : v + cnt_t'(1);
	endfunction

endpackage

FILE: design/rst_cfg_regs.sv
// ----------------------------------------------------------------------------
// rst_cfg_regs
// Tolerance and limit registers, written through the configuration port.
// ----------------------------------------------------------------------------
module rst_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [rst_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rst_pkg::CFG_DATA_W-1:0] wr_data,
	output rst_pkg::cfg_t                   cfg
);

	rst_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_tol   <= rst_pkg::LIN_TOL_RST;
			cfg_q.ang_tol   <= rst_pkg::ANG_TOL_RST;
			cfg_q.int_tol   <= rst_pkg::INT_TOL_RST;
			cfg_q.still_lim <= rst_pkg::STILL_LIM_RST;
			cfg_q.sleep_lim <= rst_pkg::SLEEP_LIM_RST;
		end else if (wr_en) begin
			case (wr_index)
				rst_pkg::REG_LIN_TOL:   cfg_q.lin_tol   <= wr_data;
				rst_pkg::REG_ANG_TOL:   cfg_q.ang_tol   <= wr_data;
				rst_pkg::REG_INT_TOL:   cfg_q.int_tol   <= wr_data;
				rst_pkg::REG_STILL_LIM: cfg_q.still_lim <= wr_data[rst_pkg::LIM_W-1:0];
				rst_pkg::REG_SLEEP_LIM: cfg_q.sleep_lim <= wr_data[rst_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/rst_core.sv
// ----------------------------------------------------------------------------
// rst_core
// Input register, body state update and result register.
// ----------------------------------------------------------------------------
module rst_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rst_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [rst_pkg::MEAS_W-1:0]   ang_speed_sq,
	input  logic [rst_pkg::MEAS_W-1:0]   lin_speed_sq,
	input  logic signed [rst_pkg::DIFF_W-1:0] ang_next_diff,
	input  logic signed [rst_pkg::DIFF_W-1:0] lin_next_diff,
	input  logic [rst_pkg::MEAS_W-1:0]   internal_motion,
	input  logic [rst_pkg::LIM_W-1:0]    blocked_updates,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   sleep_mode,
	output logic                         nearly_still,
	output logic [15:0]                  still_count,
	output logic [15:0]                  sleep_count
);

	localparam int MW = rst_pkg::MEAS_W;
	localparam int CW = rst_pkg::CMP_W;
	localparam int LW = rst_pkg::LIM_W;

	// input stage
	logic                     valid_s1;
	logic [1:0]               mode_s1;
	logic [MW-1:0]            ang_s1, lin_s1, int_s1;
	logic [rst_pkg::DIFF_W-1:0] angd_s1, lind_s1;
	logic [LW-1:0]            blk_s1;

	// body state
	logic [1:0]      body_mode_q;
	rst_pkg::cnt_t   motionless_q, asleep_q;

	// result stage
	logic            out_valid_q;
	logic [1:0]      mode_s2;
	logic            still_s2;
	rst_pkg::cnt_t   motionless_s2, asleep_s2;

	logic advance, take;
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			ang_s1  <= ang_speed_sq;
			lin_s1  <= lin_speed_sq;
			angd_s1 <= ang_next_diff;
			lind_s1 <= lin_next_diff;
			int_s1  <= internal_motion;
			blk_s1  <= blocked_updates;
		end
	end

	// still test; a negative difference always passes
	logic ok;
	always_comb begin
		ok = (ang_s1 <= MW'(cfg.ang_tol))
			&& (lin_s1 <= MW'(cfg.lin_tol))
			&& (angd_s1[rst_pkg::DIFF_W-1] || (angd_s1[MW-1:0] <= MW'(cfg.ang_tol)))
			&& (lind_s1[rst_pkg::DIFF_W-1] || (lind_s1[MW-1:0] <= MW'(cfg.lin_tol)))
			&& (int_s1 <= MW'(cfg.int_tol));
	end

	logic [1:0]    nx_mode;
	rst_pkg::cnt_t nx_motionless, nx_asleep;
	logic          nx_still;
	logic [LW:0]   tgt_raw;
	logic [LW-1:0] tgt;

	always_comb begin
		nx_mode       = body_mode_q;
		nx_motionless = motionless_q;
		nx_asleep     = asleep_q;
		nx_still      = 1'b0;
		tgt_raw       = {1'b0, cfg.sleep_lim} - {1'b0, blk_s1} - (LW+1)'(1);
		tgt           = tgt_raw[LW] ? '0 : tgt_raw[LW-1:0];
		case (mode_s1)
			rst_pkg::CMD_TICK: begin
				if (ok) begin
					nx_still = 1'b1;
					if (body_mode_q == rst_pkg::MODE_AWAKE) begin
						nx_motionless = rst_pkg::sat_inc(motionless_q);
						if (CW'(nx_motionless) >= CW'(cfg.still_lim))
							nx_mode = rst_pkg::MODE_ASLEEP;
					end
					// falls straight into asleep counting on the tick that sleeps
					if (nx_mode != rst_pkg::MODE_AWAKE) begin
						nx_asleep = rst_pkg::sat_inc(asleep_q);
						if (CW'(nx_asleep) >= CW'(cfg.sleep_lim))
							nx_mode = rst_pkg::MODE_DONE;
					end
				end else if (body_mode_q == rst_pkg::MODE_AWAKE) begin
					nx_motionless = '0;
					nx_asleep     = '0;
				end else begin
					nx_mode = rst_pkg::MODE_AWAKE;
				end
			end
			rst_pkg::CMD_WAKE: begin
				nx_mode = rst_pkg::MODE_AWAKE;
			end
			rst_pkg::CMD_RESET: begin
				nx_mode       = rst_pkg::MODE_AWAKE;
				nx_motionless = '0;
				nx_asleep     = '0;
			end
			rst_pkg::CMD_BLOCK: begin
				if (body_mode_q != rst_pkg::MODE_AWAKE) begin
					if (CW'(tgt) < CW'(asleep_q))
						nx_asleep = rst_pkg::cnt_t'(tgt);
					nx_mode = rst_pkg::MODE_ASLEEP;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_mode_q  <= rst_pkg::MODE_AWAKE;
			motionless_q <= '0;
			asleep_q     <= '0;
		end else if (advance) begin
			body_mode_q  <= nx_mode;
			motionless_q <= nx_motionless;
			asleep_q     <= nx_asleep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2       <= nx_mode;
			still_s2      <= nx_still;
			motionless_s2 <= nx_motionless;
			asleep_s2     <= nx_asleep;
		end
	end

	assign out_valid    = out_valid_q;
	assign sleep_mode   = mode_s2;
	assign nearly_still = still_s2;
	assign still_count  = 16'(motionless_s2);
	assign sleep_count  = 16'(asleep_s2);

	// state only moves when a beat leaves the input stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(body_mode_q) && $stable(motionless_q) && $stable(asleep_q))
		else $error("body state changed without a beat");

	a_reset_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 == rst_pkg::CMD_RESET |=>
			motionless_q == '0 && asleep_q == '0 && body_mode_q == rst_pkg::MODE_AWAKE)
		else $error("reset command left state behind");

	a_still_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 != rst_pkg::CMD_TICK |=> !still_s2)
		else $error("nearly_still set on a non-tick command");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> mode_s2 == body_mode_q && motionless_s2 == motionless_q
			&& asleep_s2 == asleep_q)
		else $error("result register out of step with body state");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while result stage empty");

endmodule

FILE: design/rest_sleep_tracker.sv
// An accepted beat waits in the input register, then moves into the result
// register with the body state update; a full, unread result register stalls it.
// Throughput: one beat per cycle while the receiver takes results, set by the single
// state update between the input register and the result register.
// Reset: arst_n clears body mode to awake, both counters to zero and loads
// the tolerance and limit registers with their defaults.
// ----------------------------------------------------------------------------
// rest_sleep_tracker
// Per-body rest detector: awake, asleep and done sleeping, with tick counters.
// ----------------------------------------------------------------------------
module rest_sleep_tracker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rst_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       mode,
	input  logic [30:0]                      ang_speed_sq,
	input  logic [30:0]                      lin_speed_sq,
	input  logic signed [31:0]               ang_next_diff,
	input  logic signed [31:0]               lin_next_diff,
	input  logic [30:0]                      internal_motion,
	input  logic [13:0]                      blocked_updates,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       sleep_mode,
	output logic                             nearly_still,
	output logic [15:0]                      still_count,
	output logic [15:0]                      sleep_count
);

	rst_pkg::cfg_t cfg;

	assign cfg_ready = 1'b1;

	rst_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rst_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.ang_speed_sq    (ang_speed_sq),
		.lin_speed_sq    (lin_speed_sq),
		.ang_next_diff   (ang_next_diff),
		.lin_next_diff   (lin_next_diff),
		.internal_motion (internal_motion),
		.blocked_updates (blocked_updates),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sleep_mode      (sleep_mode),
		.nearly_still    (nearly_still),
		.still_count     (still_count),
		.sleep_count     (sleep_count)
	);

endmodule

FILE: tb/sv/tb_rest_sleep_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rest_sleep_tracker
// Self-checking bench for the rest/sleep tracker. Command beats are driven
// on the valid/ready input while a local model of the body mode and the tick
// counters predicts every result beat. Results are compared field by field in
// order. Directed cases cover the tolerance compares, the mode walk, config
// extremes and a long counter climb. Random phases follow under varying idle
// mixes and back-pressure.
// ----------------------------------------------------------------------------
module tb_rest_sleep_tracker;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int TAIL_CYCLES  = 8;
	localparam int RANDOM_BEATS = 380;
	localparam int CLIMB_PAIRS  = 20;
	localparam logic [rst_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // decodes to no register
	localparam logic [rst_pkg::LIM_W-1:0]  LIM_MAX  = '1;
	localparam logic [rst_pkg::TOL_W-1:0]  TOL_MAX  = '1;
	localparam logic [rst_pkg::MEAS_W-1:0] MEAS_MAX = '1;

	typedef struct {
		logic [1:0]                        mode;
		logic [rst_pkg::MEAS_W-1:0]        ang;
		logic [rst_pkg::MEAS_W-1:0]        lin;
		logic signed [rst_pkg::DIFF_W-1:0] ang_diff;
		logic signed [rst_pkg::DIFF_W-1:0] lin_diff;
		logic [rst_pkg::MEAS_W-1:0]        internal;
		logic [rst_pkg::LIM_W-1:0]         blocked;
	} body_cmd_t;

	typedef struct {
		logic [1:0]  body;
		logic        still;
		logic [15:0] still_cnt;
		logic [15:0] sleep_cnt;
	} body_result_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [rst_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [rst_pkg::CFG_DATA_W-1:0]    cfg_data;
	logic                              in_valid;
	logic                              in_ready;
	logic [1:0]                        mode;
	logic [30:0]                       ang_speed_sq;
	logic [30:0]                       lin_speed_sq;
	logic signed [31:0]                ang_next_diff;
	logic signed [31:0]                lin_next_diff;
	logic [30:0]                       internal_motion;
	logic [13:0]                       blocked_updates;
	logic                              out_valid;
	logic                              out_ready;
	logic [1:0]                        sleep_mode;
	logic                              nearly_still;
	logic [15:0]                       still_count;
	logic [15:0]                       sleep_count;

	rest_sleep_tracker dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.ang_speed_sq    (ang_speed_sq),
		.lin_speed_sq    (lin_speed_sq),
		.ang_next_diff   (ang_next_diff),
		.lin_next_diff   (lin_next_diff),
		.internal_motion (internal_motion),
		.blocked_updates (blocked_updates),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sleep_mode      (sleep_mode),
		.nearly_still    (nearly_still),
		.still_count     (still_count),
		.sleep_count     (sleep_count)
	);

	// local copy of body state and registers
	logic [1:0]    body_mode;
	rst_pkg::cnt_t motionless;
	rst_pkg::cnt_t asleep;
	rst_pkg::cfg_t tracker_cfg;

	body_result_t pending_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int failures;
	int beats_sent;
	int results_checked;
	int reg_writes;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic rst_pkg::cnt_t count_up(input rst_pkg::cnt_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// advance the body state by one command and return the result beat
	function automatic body_result_t advance_body(input body_cmd_t c);
		body_result_t r;
		logic         still;
		int           target;
		still = 1'b0;
		case (c.mode)
			rst_pkg::CMD_TICK: begin
				still = (c.ang <= tracker_cfg.ang_tol) && (c.lin <= tracker_cfg.lin_tol)
					&& (c.ang_diff <= $signed({8'd0, tracker_cfg.ang_tol}))
					&& (c.lin_diff <= $signed({8'd0, tracker_cfg.lin_tol}))
					&& (c.internal <= tracker_cfg.int_tol);
				if (still) begin
					if (body_mode == rst_pkg::MODE_AWAKE) begin
						motionless = count_up(motionless);
						if (motionless >= tracker_cfg.still_lim)
							body_mode = rst_pkg::MODE_ASLEEP;
					end
					if (body_mode != rst_pkg::MODE_AWAKE) begin
						asleep = count_up(asleep);
						if (asleep >= tracker_cfg.sleep_lim)
							body_mode = rst_pkg::MODE_DONE;
					end
				end else if (body_mode == rst_pkg::MODE_AWAKE) begin
					motionless = '0;
					asleep     = '0;
				end else begin
					body_mode = rst_pkg::MODE_AWAKE;
				end
			end
			rst_pkg::CMD_WAKE: begin
				body_mode = rst_pkg::MODE_AWAKE;
			end
			rst_pkg::CMD_RESET: begin
				motionless = '0;
				asleep     = '0;
				body_mode  = rst_pkg::MODE_AWAKE;
			end
			default: begin
				if (body_mode != rst_pkg::MODE_AWAKE) begin
					target = int'(tracker_cfg.sleep_lim) - int'(c.blocked) - 1;
					if (target < 0)
						target = 0;
					if (target < int'(asleep))
						asleep = rst_pkg::cnt_t'(target);
					body_mode = rst_pkg::MODE_ASLEEP;
				end
			end
		endcase
		r.body      = body_mode;
		r.still     = still;
		r.still_cnt = motionless[15:0];
		r.sleep_cnt = asleep[15:0];
		return r;
	endfunction

	function automatic body_cmd_t cmd_beat(input logic [1:0] m, input logic [30:0] ang,
		input logic [30:0] lin, input logic [31:0] ang_d, input logic [31:0] lin_d,
		input logic [30:0] inter, input logic [13:0] blk);
		body_cmd_t c;
		c.mode     = m;
		c.ang      = ang;
		c.lin      = lin;
		c.ang_diff = ang_d;
		c.lin_diff = lin_d;
		c.internal = inter;
		c.blocked  = blk;
		return c;
	endfunction

	function automatic body_cmd_t tick_beat(input logic [30:0] ang, input logic [30:0] lin,
		input logic [31:0] ang_d, input logic [31:0] lin_d, input logic [30:0] inter);
		return cmd_beat(rst_pkg::CMD_TICK, ang, lin, ang_d, lin_d, inter, 14'($urandom));
	endfunction

	function automatic body_cmd_t ctrl_beat(input logic [1:0] m, input logic [13:0] blk);
		return cmd_beat(m, 31'($urandom), 31'($urandom), $urandom, $urandom, 31'($urandom),
			blk);
	endfunction

	function automatic logic [30:0] meas_within(input logic [rst_pkg::TOL_W-1:0] tol);
		case ($urandom_range(3))
			0:       return '0;
			1:       return 31'(tol);
			default: return 31'($urandom_range(tol));
		endcase
	endfunction

	function automatic logic [30:0] meas_above(input logic [rst_pkg::TOL_W-1:0] tol);
		if ($urandom_range(3) == 0)
			return 31'(tol) + 1'b1;
		return 31'($urandom_range(32'h7FFF_FFFF, 32'(tol) + 1));
	endfunction

	function automatic logic [31:0] diff_within(input logic [rst_pkg::TOL_W-1:0] tol);
		case ($urandom_range(3))
			0:       return {1'b1, 31'($urandom)};
			1:       return 32'(tol);
			default: return 32'($urandom_range(tol));
		endcase
	endfunction

	// mostly ticks, many still, some with one measure out of range; also wake/reset/block
	function automatic body_cmd_t random_cmd();
		body_cmd_t c;
		int        pick;
		c = ctrl_beat(rst_pkg::CMD_TICK, ($urandom_range(2) == 0) ? 14'($urandom) :
			14'($urandom_range(12)));
		pick = $urandom_range(99);
		if (pick < 70)
			c.mode = rst_pkg::CMD_TICK;
		else if (pick < 80)
			c.mode = rst_pkg::CMD_WAKE;
		else if (pick < 86)
			c.mode = rst_pkg::CMD_RESET;
		else
			c.mode = rst_pkg::CMD_BLOCK;
		if (c.mode == rst_pkg::CMD_TICK && $urandom_range(9) != 0) begin
			c.ang      = meas_within(tracker_cfg.ang_tol);
			c.lin      = meas_within(tracker_cfg.lin_tol);
			c.ang_diff = diff_within(tracker_cfg.ang_tol);
			c.lin_diff = diff_within(tracker_cfg.lin_tol);
			c.internal = meas_within(tracker_cfg.int_tol);
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(4))
					0:       c.ang      = meas_above(tracker_cfg.ang_tol);
					1:       c.lin      = meas_above(tracker_cfg.lin_tol);
					2:       c.ang_diff = {1'b0, meas_above(tracker_cfg.ang_tol)};
					3:       c.lin_diff = {1'b0, meas_above(tracker_cfg.lin_tol)};
					default: c.internal = meas_above(tracker_cfg.int_tol);
				endcase
			end
		end
		return c;
	endfunction

	function automatic logic [rst_pkg::CFG_DATA_W-1:0] pick_tol();
		case ($urandom_range(7))
			0:       return '0;
			1:       return TOL_MAX;
			2:       return 26'($urandom);
			3:       return 26'($urandom_range(70000));
			default: return 26'($urandom_range(1000));
		endcase
	endfunction

	// upper bits of the word are junk, only the low limit bits count
	function automatic logic [rst_pkg::CFG_DATA_W-1:0] pick_lim();
		logic [rst_pkg::LIM_W-1:0] lim;
		case ($urandom_range(9))
			0:       lim = '0;
			1:       lim = LIM_MAX;
			default: lim = 14'($urandom_range(12));
		endcase
		return {12'($urandom), lim};
	endfunction

	task automatic push_cmd(input body_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid        <= 1'b1;
		mode            <= c.mode;
		ang_speed_sq    <= c.ang;
		lin_speed_sq    <= c.lin;
		ang_next_diff   <= c.ang_diff;
		lin_next_diff   <= c.lin_diff;
		internal_motion <= c.internal;
		blocked_updates <= c.blocked;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_results.push_back(advance_body(c));
		beats_sent++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rst_pkg::CFG_IDX_W-1:0] idx,
		input logic [rst_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			rst_pkg::REG_LIN_TOL:   tracker_cfg.lin_tol   = data;
			rst_pkg::REG_ANG_TOL:   tracker_cfg.ang_tol   = data;
			rst_pkg::REG_INT_TOL:   tracker_cfg.int_tol   = data;
			rst_pkg::REG_STILL_LIM: tracker_cfg.still_lim = data[rst_pkg::LIM_W-1:0];
			rst_pkg::REG_SLEEP_LIM: tracker_cfg.sleep_lim = data[rst_pkg::LIM_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [rst_pkg::CFG_DATA_W-1:0] lin_tol,
		input logic [rst_pkg::CFG_DATA_W-1:0] ang_tol,
		input logic [rst_pkg::CFG_DATA_W-1:0] int_tol,
		input logic [rst_pkg::CFG_DATA_W-1:0] still_lim,
		input logic [rst_pkg::CFG_DATA_W-1:0] sleep_lim);
		write_reg(rst_pkg::REG_LIN_TOL, lin_tol);
		write_reg(rst_pkg::REG_ANG_TOL, ang_tol);
		write_reg(rst_pkg::REG_INT_TOL, int_tol);
		write_reg(rst_pkg::REG_STILL_LIM, still_lim);
		write_reg(rst_pkg::REG_SLEEP_LIM, sleep_lim);
	endtask

	task automatic note_mismatch(input string field, input longint want, input longint got);
		failures++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// receiver: random idling plus an optional long hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		body_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				failures++;
				$error("result beat with nothing pending");
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (sleep_mode !== want.body)
					note_mismatch("sleep_mode", want.body, sleep_mode);
				if (nearly_still !== want.still)
					note_mismatch("nearly_still", want.still, nearly_still);
				if (still_count !== want.still_cnt)
					note_mismatch("still_count", want.still_cnt, still_count);
				if (sleep_count !== want.sleep_cnt)
					note_mismatch("sleep_count", want.sleep_cnt, sleep_count);
			end
		end
	end

	// boundary compares against the reset tolerances
	task automatic test_still_compare();
		push_cmd(tick_beat('0, '0, '0, '0, '0));
		push_cmd(tick_beat(31'd655, 31'd328, 32'd655, 32'd328, 31'd13107));
		push_cmd(tick_beat(31'd656, '0, '0, '0, '0));
		push_cmd(tick_beat('0, 31'd329, '0, '0, '0));
		push_cmd(tick_beat('0, '0, 32'd656, '0, '0));
		push_cmd(tick_beat('0, '0, '0, 32'd329, '0));
		push_cmd(tick_beat('0, '0, '0, '0, 31'd13108));
		push_cmd(tick_beat('0, '0, 32'h8000_0000, 32'h8000_0000, '0));
		push_cmd(tick_beat(MEAS_MAX, MEAS_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, MEAS_MAX));
		wait_results_drained();
	endtask

	// awake -> asleep -> done, block, wake, reset, motion while asleep
	task automatic test_mode_walk();
		write_reg(rst_pkg::REG_STILL_LIM, 26'd2);
		write_reg(rst_pkg::REG_SLEEP_LIM, 26'd3);
		push_cmd(ctrl_beat(rst_pkg::CMD_RESET, '0));
		repeat (5) push_cmd(tick_beat('0, '0, '0, '0, '0));
		push_cmd(ctrl_beat(rst_pkg::CMD_BLOCK, '0));
		push_cmd(ctrl_beat(rst_pkg::CMD_BLOCK, LIM_MAX));
		push_cmd(ctrl_beat(rst_pkg::CMD_WAKE, '0));
		push_cmd(ctrl_beat(rst_pkg::CMD_BLOCK, 14'd1));
		push_cmd(tick_beat('0, '0, '0, '0, MEAS_MAX));
		push_cmd(tick_beat('0, '0, '0, '0, '0));
		push_cmd(tick_beat('0, '0, '0, '0, '0));
		push_cmd(tick_beat(MEAS_MAX, '0, '0, '0, '0));
		push_cmd(ctrl_beat(rst_pkg::CMD_RESET, '0));
		wait_results_drained();
	endtask

	// zero and full-scale registers, plus a write to an unused index
	task automatic test_config_extremes();
		write_all('0, '0, '0, '0, '0);
		write_reg(REG_SPARE, TOL_MAX);
		push_cmd(tick_beat('0, '0, '0, '0, '0));
		push_cmd(tick_beat(31'd1, '0, '0, '0, '0));
		push_cmd(tick_beat('0, '0, '0, '0, '0));
		wait_results_drained();
		write_all(TOL_MAX, TOL_MAX, TOL_MAX, {12'hFFF, LIM_MAX}, {12'hFFF, LIM_MAX});
		push_cmd(tick_beat(31'(TOL_MAX), 31'(TOL_MAX), 32'(TOL_MAX), 32'(TOL_MAX),
			31'(TOL_MAX)));
		push_cmd(tick_beat(31'(TOL_MAX) + 1'b1, '0, '0, '0, '0));
		push_cmd(tick_beat('0, '0, 32'h8000_0000, 32'(TOL_MAX) + 1, '0));
		wait_results_drained();
	endtask

	// wake/tick pairs keep both counters climbing without a reset
	task automatic test_counter_climb();
		write_all(26'd328, 26'd655, 26'd13107, '0, {12'd0, LIM_MAX});
		push_cmd(ctrl_beat(rst_pkg::CMD_RESET, '0));
		for (int k = 0; k < CLIMB_PAIRS; k++) begin
			push_cmd(tick_beat('0, '0, '0, '0, '0));
			push_cmd(ctrl_beat(rst_pkg::CMD_WAKE, '0));
		end
		push_cmd(tick_beat('0, '0, '0, '0, '0));
		push_cmd(ctrl_beat(rst_pkg::CMD_BLOCK, '0));
		push_cmd(ctrl_beat(rst_pkg::CMD_RESET, '0));
		wait_results_drained();
	endtask

	// long receiver stall while the sender keeps offering beats
	task automatic test_backpressure();
		write_all(26'd500, 26'd500, 26'd5000, 26'd4, 26'd6);
		hold_left = 300;
		repeat (40) push_cmd(random_cmd());
		wait_results_drained();
	endtask

	task automatic test_random_phase(input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		write_all(pick_tol(), pick_tol(), pick_tol(), pick_lim(), pick_lim());
		for (int k = 0; k < RANDOM_BEATS; k++) begin
			if (k == RANDOM_BEATS / 2) begin
				// sender pause until everything is back
				wait_results_drained();
				write_reg(rst_pkg::REG_STILL_LIM, pick_lim());
				write_reg(rst_pkg::REG_SLEEP_LIM, pick_lim());
			end
			push_cmd(random_cmd());
		end
		wait_results_drained();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		mode            = rst_pkg::CMD_TICK;
		ang_speed_sq    = '0;
		lin_speed_sq    = '0;
		ang_next_diff   = '0;
		lin_next_diff   = '0;
		internal_motion = '0;
		blocked_updates = '0;
		send_idle_pct   = 12;
		recv_idle_pct   = 63;
		hold_left       = 0;
		failures        = 0;
		beats_sent      = 0;
		results_checked = 0;
		reg_writes      = 0;
		cycles          = 0;
		body_mode       = rst_pkg::MODE_AWAKE;
		motionless      = '0;
		asleep          = '0;
		tracker_cfg.lin_tol   = rst_pkg::LIN_TOL_RST;
		tracker_cfg.ang_tol   = rst_pkg::ANG_TOL_RST;
		tracker_cfg.int_tol   = rst_pkg::INT_TOL_RST;
		tracker_cfg.still_lim = rst_pkg::STILL_LIM_RST;
		tracker_cfg.sleep_lim = rst_pkg::SLEEP_LIM_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_still_compare();
		test_mode_walk();
		test_config_extremes();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_counter_climb();
		test_backpressure();
		test_random_phase(12, 63);
		test_random_phase(63, 12);
		test_random_phase(0, 0);

		wait_results_drained();
		$display("covered %0d command beats, %0d result beats, %0d register writes",
			beats_sent, results_checked, reg_writes);
		$display("tolerance edges, mode walk, register extremes, counter climb, stall");
		if (failures == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
